/* src/error_diffusion_pattern_halftoner_core_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the error diffusion pattern halftoner.
// ---------------------------------------------------------------------------
`ifndef ERROR_DIFFUSION_PATTERN_HALFTONER_CORE_DEFINES_SVH
`define ERROR_DIFFUSION_PATTERN_HALFTONER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EDPH_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("halftoner assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define EDPH_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("halftoner assertion failed");

`endif

/* src/edph_pkg.sv */
// ---------------------------------------------------------------------------
// edph_pkg
// Shared constants, register indexes and the dot placement table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package edph_pkg;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int ERROR_BITS_DEF = 16;
  localparam int MAX_PATTERN    = 8;
  localparam int DIV_STEPS      = 18;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PATTERN_SIZE,
    REG_IMAGE_WIDTH,
    REG_COLOR_GAIN,
    REG_HORIZONTAL_MODE
  } reg_index_t;

  localparam logic [3:0]  PATTERN_SIZE_RST    = 4'd5;
  localparam logic [12:0] IMAGE_WIDTH_RST     = 13'd640;
  localparam logic [15:0] COLOR_GAIN_RST      = 16'd4096;
  localparam logic        HORIZONTAL_MODE_RST = 1'b1;

  // Rank of each mask bit in fill order, per orientation and pattern side.
  // Bits outside the cell get the largest rank and are never set.
  typedef logic [1:0][MAX_PATTERN-1:0][63:0][6:0] rank_table_t;

  function automatic rank_table_t build_rank_table();
    rank_table_t tbl;
    int placed;
    int b;
    tbl = '1;
    for (int h = 0; h < 2; h++) begin
      for (int n = 1; n <= MAX_PATTERN; n++) begin
        placed = 0;
        for (int pass = 0; pass < 2; pass++) begin
          for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
              if (((i + j) % 2) == pass) begin
                b = (h == 1) ? (i * n + j) : (j * n + i);
                tbl[h][n-1][b] = 7'(placed);
                placed++;
              end
            end
          end
        end
      end
    end
    return tbl;
  endfunction

  localparam rank_table_t RANK_TABLE = build_rank_table();

endpackage

/* src/error_diffusion_pattern_halftoner_core.sv */
// A pixel passes READ, LEVEL, INDEX, GAIN, SCALE, the 18-step serial divider
// that splits the quantization error, FIX and SHARE, which registers the
// result when the output is free, then LAST at row end; one pixel at a time.
// Reset (rst, synchronous): configuration returns to its defaults, all
// diffused error clears and the counters restart; the row store is not swept.
`timescale 1ns / 1ps
`include "error_diffusion_pattern_halftoner_core_defines.svh"
// ---------------------------------------------------------------------------
// error_diffusion_pattern_halftoner_core
// Floyd-Steinberg halftoner that turns gray pixels into dot patterns, with
// the next-row error kept in a line memory with one write and one read port.
// ---------------------------------------------------------------------------

module error_diffusion_pattern_halftoner_core #(
  parameter int MAX_WIDTH  = edph_pkg::MAX_WIDTH_DEF,
  parameter int ERROR_BITS = edph_pkg::ERROR_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,  // pixel
  input  logic                                s_tuser,  // frame_start
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // dot_count[6:0], dot_mask[70:7], column[82:71], line_index[94:83], zero
  output logic [95:0]                         m_tdata,
  input  logic                                cfg_we,
  input  logic [edph_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [edph_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import edph_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int SW = 26;
  localparam logic signed [SW-1:0] ERR_HI = SW'((64'sd1 <<< (ERROR_BITS - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] ERR_LO = -ERR_HI - SW'(1);

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_LEVEL, S_INDEX, S_GAIN, S_SCALE, S_DIV, S_FIX, S_SHARE, S_LAST
  } state_t;

  function automatic logic signed [ERROR_BITS-1:0] sat_err(input logic signed [SW-1:0] x);
    logic signed [SW-1:0] y;
    y = x;
    if (x > ERR_HI) y = ERR_HI;
    if (x < ERR_LO) y = ERR_LO;
    return ERROR_BITS'(y);
  endfunction

  function automatic logic signed [SW-1:0] share(input logic signed [18:0] qq,
                                                 input logic [10:0] rr,
                                                 input logic [10:0] dd,
                                                 input logic [2:0] w);
    logic [13:0] wr;
    logic [13:0] kd;
    logic [2:0]  f;
    wr = 14'(rr) * 14'(w);
    f  = 3'd0;
    for (int k = 1; k < 7; k++) begin
      kd = 14'(dd) * 14'(k);
      if (wr >= kd) f = f + 3'd1;
    end
    return SW'(qq) * SW'($signed({1'b0, w})) + SW'($signed({1'b0, f}));
  endfunction

  state_t state;

  logic [3:0]  pattern_size;
  logic [12:0] image_width;
  logic signed [15:0] color_gain;
  logic        horizontal_mode;

  logic [AW-1:0] col_cnt;
  logic [11:0]   row_cnt;
  logic          first_row;
  logic signed [ERROR_BITS-1:0] right_err;
  logic signed [ERROR_BITS-1:0] pend0;
  logic signed [ERROR_BITS-1:0] pend1;

  logic [7:0]          pix_q;
  logic [12:0]         v_q;
  logic [18:0]         vt_q;
  logic [10:0]         y_q;
  logic signed [7:0]   idx_q;
  logic signed [23:0]  prod_q;
  logic [6:0]          dots_q;
  logic [3:0]          qlow_q;
  logic                neg_q;
  logic [DIV_STEPS-1:0] div_a;
  logic [6:0]          div_rem;
  logic [4:0]          div_cnt;
  logic signed [18:0]  quo_q;
  logic [10:0]         rem_q;

  logic          out_valid;
  logic [95:0]   out_data;

  logic signed [ERROR_BITS-1:0] err_mem [MAX_WIDTH];
  logic signed [ERROR_BITS-1:0] rd_data;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic signed [ERROR_BITS-1:0] mem_wdata;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  logic [3:0]  n_eff;
  logic [6:0]  nn;
  logic [6:0]  tt;
  logic [10:0] dd;
  logic [31:0] w_eff;
  logic        last;
  logic        accept;
  logic        out_free;

  logic signed [SW-1:0] e7, e3, e5, e1;
  logic signed [SW-1:0] sum_v;
  logic signed [SW-1:0] sat_v;
  logic [16:0] y41;
  logic [6:0]  q0;
  logic [11:0] q25;
  logic [23:0] pmag;
  logic signed [10:0] s_val;
  logic signed [11:0] dots_full;
  logic signed [23:0] q_val;
  logic signed [19:0] q1;
  logic [19:0] q1_mag;
  logic [7:0]  rem2;
  logic [63:0] mask;
  logic [31:0] col32;

  always_comb begin
    n_eff = pattern_size;
    if (pattern_size == 4'd0) n_eff = 4'd1;
    if (32'(pattern_size) > MAX_PATTERN) n_eff = 4'(MAX_PATTERN);
    nn = 7'(n_eff) * 7'(n_eff);
    tt = nn + 7'd1;
    dd = {tt, 4'b0000};
    w_eff = 32'(image_width);
    if (image_width == 13'd0) w_eff = 32'd1;
    if (32'(image_width) > MAX_WIDTH) w_eff = 32'(MAX_WIDTH);
    col32 = 32'(col_cnt);
    last = (col32 + 32'd1) >= w_eff;
  end

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  assign out_free = !out_valid || m_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  assign rd_en   = accept;
  assign rd_addr = s_tuser ? '0 : col_cnt;

  always_comb begin
    sum_v = SW'($signed({1'b0, pix_q, 6'b000000})) + SW'(right_err);
    if (!first_row) sum_v = sum_v + SW'(rd_data);
    sat_v = SW'(sat_err(sum_v));

    y41 = 17'(y_q) * 17'(41);
    q0  = 7'(y41 >> 10);
    q25 = 12'(q0) * 12'(25);

    pmag  = prod_q[23] ? 24'(-prod_q) : 24'(prod_q);
    s_val = prod_q[23] ? -$signed(11'(pmag >> 12)) : $signed(11'(pmag >> 12));
    dots_full = $signed({5'b0, nn}) - 12'(s_val);
    q_val = $signed({5'b0, vt_q}) - $signed(24'(s_val)) * 24'sd6400;
    q1 = 20'(q_val >>> 4);
    q1_mag = q1[19] ? 20'(-q1) : 20'(q1);

    rem2 = {div_rem, div_a[DIV_STEPS-1]};

    e7 = share(quo_q, rem_q, dd, 3'd7);
    e3 = share(quo_q, rem_q, dd, 3'd3);
    e5 = share(quo_q, rem_q, dd, 3'd5);
    e1 = share(quo_q, rem_q, dd, 3'd1);

    for (int b = 0; b < 64; b++) begin
      mask[b] = RANK_TABLE[horizontal_mode][3'(n_eff - 4'd1)][b] < dots_q;
    end

    mem_we    = 1'b0;
    mem_waddr = col_cnt;
    mem_wdata = pend0;
    if (state == S_SHARE && out_free && col_cnt != '0) begin
      mem_we    = 1'b1;
      mem_waddr = col_cnt - AW'(1);
      mem_wdata = sat_err(SW'(pend0) + e3);
    end
    if (state == S_LAST) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      err_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data <= err_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      pattern_size    <= PATTERN_SIZE_RST;
      image_width     <= IMAGE_WIDTH_RST;
      color_gain      <= COLOR_GAIN_RST;
      horizontal_mode <= HORIZONTAL_MODE_RST;
      col_cnt         <= '0;
      row_cnt         <= '0;
      first_row       <= 1'b1;
      right_err       <= '0;
      pend0           <= '0;
      pend1           <= '0;
      out_valid       <= 1'b0;
      div_cnt         <= '0;
    end else begin
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_PATTERN_SIZE:    pattern_size    <= cfg_data[3:0];
          REG_IMAGE_WIDTH:     image_width     <= cfg_data[12:0];
          REG_COLOR_GAIN:      color_gain      <= $signed(cfg_data[15:0]);
          REG_HORIZONTAL_MODE: horizontal_mode <= cfg_data[0];
          default: ;
        endcase
      end

      if (out_valid && m_tready && state != S_SHARE) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            pix_q <= s_tdata;
            if (s_tuser) begin
              col_cnt   <= '0;
              row_cnt   <= '0;
              right_err <= '0;
              pend0     <= '0;
              pend1     <= '0;
              first_row <= 1'b1;
            end
            state <= S_READ;
          end
        end
        S_READ: begin
          if (sat_v < 0) begin
            v_q <= 13'd0;
          end else if (sat_v > SW'(6400)) begin
            v_q <= 13'd6400;
          end else begin
            v_q <= 13'(sat_v);
          end
          state <= S_LEVEL;
        end
        S_LEVEL: begin
          vt_q  <= 19'(v_q) * 19'(tt);
          y_q   <= 11'((20'(v_q) * 20'(tt) + 20'd6399) >> 8);
          state <= S_INDEX;
        end
        S_INDEX: begin
          if (q25 > 12'(y_q)) begin
            idx_q <= $signed(8'(q0) - 8'd2);
          end else begin
            idx_q <= $signed(8'(q0) - 8'd1);
          end
          state <= S_GAIN;
        end
        S_GAIN: begin
          prod_q <= $signed(24'(idx_q)) * $signed(24'(color_gain));
          state  <= S_SCALE;
        end
        S_SCALE: begin
          if (dots_full < 0) begin
            dots_q <= 7'd0;
          end else if (dots_full > $signed({5'b0, nn})) begin
            dots_q <= nn;
          end else begin
            dots_q <= 7'(dots_full);
          end
          qlow_q  <= q_val[3:0];
          neg_q   <= q1[19];
          div_a   <= DIV_STEPS'(q1_mag);
          div_rem <= '0;
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          if (rem2 >= {1'b0, tt}) begin
            div_rem <= 7'(rem2 - {1'b0, tt});
            div_a   <= {div_a[DIV_STEPS-2:0], 1'b1};
          end else begin
            div_rem <= 7'(rem2);
            div_a   <= {div_a[DIV_STEPS-2:0], 1'b0};
          end
          if (div_cnt == 5'(DIV_STEPS - 1)) begin
            state <= S_FIX;
          end else begin
            div_cnt <= div_cnt + 5'd1;
          end
        end
        S_FIX: begin
          if (neg_q && div_rem != 7'd0) begin
            quo_q <= -$signed(19'(div_a)) - 19'sd1;
            rem_q <= {tt - div_rem, qlow_q};
          end else if (neg_q) begin
            quo_q <= -$signed(19'(div_a));
            rem_q <= {7'd0, qlow_q};
          end else begin
            quo_q <= $signed(19'(div_a));
            rem_q <= {div_rem, qlow_q};
          end
          state <= S_SHARE;
        end
        S_SHARE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data  <= {1'b0, row_cnt, col32[11:0], mask, dots_q};
            pend0     <= sat_err(SW'(pend1) + e5);
            pend1     <= sat_err(e1);
            right_err <= sat_err(e7);
            if (last) begin
              state <= S_LAST;
            end else begin
              col_cnt <= col_cnt + AW'(1);
              state   <= S_IDLE;
            end
          end
        end
        S_LAST: begin
          pend0     <= '0;
          pend1     <= '0;
          right_err <= '0;
          col_cnt   <= '0;
          row_cnt   <= row_cnt + 12'd1;
          first_row <= 1'b0;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `EDPH_ASSERT_NEXT(a_one_in_flight, clk, rst, accept, !s_tready)
  `EDPH_ASSERT_SAME(a_dot_count_range, clk, rst, m_tvalid, m_tdata[6:0] <= 7'd64)
  `EDPH_ASSERT_SAME(a_empty_mask, clk, rst, m_tvalid && m_tdata[6:0] == 7'd0,
                    m_tdata[70:7] == 64'd0)
  `EDPH_ASSERT_SAME(a_div_steps, clk, rst, state == S_DIV, div_cnt < 5'(DIV_STEPS))

endmodule

/* tb/sv/halftoner_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Halftoner checker
// Watches the pixel, result and register ports of the halftoner, predicts
// every result from its own copy of the error diffusion state, and compares
// each result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module halftoner_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  input  logic                                s_tready,
  input  logic [7:0]                          s_tdata,
  input  logic                                s_tuser,
  input  logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic [95:0]                         m_tdata,
  input  logic                                cfg_we,
  input  logic [edph_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [edph_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output int                                  fail_count,
  output int                                  outstanding
);
  import edph_pkg::*;

  typedef struct {
    logic [6:0]  dots;
    logic [63:0] mask;
    logic [11:0] column;
    logic [11:0] line;
  } halftone_cell_t;

  halftone_cell_t cell_queue[$];

  logic [3:0]  side_reg;
  logic [12:0] width_reg;
  logic [15:0] gain_reg;
  logic        horiz_reg;

  longint next_row_err[4096];
  longint right_err;
  longint down_err[2];
  int     col_cnt;
  int     row_cnt;
  bit     first_row;

  function automatic longint sat_q6(longint x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  function automatic longint floor_quot(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic logic [63:0] dot_pattern(int n, int dots, bit horiz);
    logic [63:0] m;
    int placed;
    m = '0;
    placed = 0;
    for (int pass = 0; pass < 2; pass++)
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++)
          if (((i + j) % 2) == pass && placed < dots) begin
            placed++;
            m[horiz ? (i * n + j) : (j * n + i)] = 1'b1;
          end
    return m;
  endfunction

  function automatic halftone_cell_t diffuse_pixel(logic [7:0] pix, logic fs);
    halftone_cell_t c;
    int n, x, width;
    longint t, v, idx, gain, s, dots, q, e7, e3, e5, e1;
    bit last;
    if (fs) begin
      col_cnt = 0;
      row_cnt = 0;
      right_err = 0;
      down_err[0] = 0;
      down_err[1] = 0;
      first_row = 1;
    end
    n = (side_reg < 1) ? 1 : (side_reg > MAX_PATTERN) ? MAX_PATTERN : side_reg;
    t = n * n + 1;
    width = (width_reg < 1) ? 1 : (width_reg > 4096) ? 4096 : width_reg;
    x = (col_cnt >= 4096) ? 4095 : col_cnt;
    last = (x + 1 >= width);
    v = longint'(pix) * 64;
    if (!first_row) v += next_row_err[x];
    v = sat_q6(v + right_err);
    if (v < 0) v = 0;
    if (v > 6400) v = 6400;
    idx = (v * t + 6399) / 6400 - 1;
    gain = longint'($signed(gain_reg));
    s = (idx * gain) / 4096;
    dots = n * n - s;
    if (dots < 0) dots = 0;
    if (dots > n * n) dots = n * n;
    q = v * t - 6400 * s;
    e7 = floor_quot(q * 7, 16 * t);
    e3 = floor_quot(q * 3, 16 * t);
    e5 = floor_quot(q * 5, 16 * t);
    e1 = floor_quot(q, 16 * t);
    if (x > 0) next_row_err[x - 1] = sat_q6(down_err[0] + e3);
    down_err[0] = sat_q6(down_err[1] + e5);
    down_err[1] = sat_q6(e1);
    right_err = sat_q6(e7);
    c.dots = 7'(dots);
    c.mask = dot_pattern(n, int'(dots), horiz_reg);
    c.column = 12'(col_cnt);
    c.line = 12'(row_cnt);
    if (last) begin
      next_row_err[x] = down_err[0];
      down_err[0] = 0;
      down_err[1] = 0;
      right_err = 0;
      col_cnt = 0;
      row_cnt = (row_cnt + 1) % 4096;
      first_row = 0;
    end else begin
      col_cnt = x + 1;
    end
    return c;
  endfunction

  always @(posedge clk) begin
    halftone_cell_t want;
    if (rst) begin
      side_reg = PATTERN_SIZE_RST;
      width_reg = IMAGE_WIDTH_RST;
      gain_reg = COLOR_GAIN_RST;
      horiz_reg = HORIZONTAL_MODE_RST;
      right_err = 0;
      down_err[0] = 0;
      down_err[1] = 0;
      col_cnt = 0;
      row_cnt = 0;
      first_row = 1;
      cell_queue.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PATTERN_SIZE:    side_reg = cfg_data[3:0];
          REG_IMAGE_WIDTH:     width_reg = cfg_data[12:0];
          REG_COLOR_GAIN:      gain_reg = cfg_data;
          REG_HORIZONTAL_MODE: horiz_reg = cfg_data[0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (cell_queue.size() == 0) begin
          $error("result transfer with no pending pixel");
          fail_count++;
        end else begin
          want = cell_queue.pop_front();
          if (m_tdata[6:0] !== want.dots) begin
            $error("dot_count expected %0d actual %0d", want.dots, m_tdata[6:0]);
            fail_count++;
          end
          if (m_tdata[70:7] !== want.mask) begin
            $error("dot_mask expected %h actual %h", want.mask, m_tdata[70:7]);
            fail_count++;
          end
          if (m_tdata[82:71] !== want.column) begin
            $error("column expected %0d actual %0d", want.column, m_tdata[82:71]);
            fail_count++;
          end
          if (m_tdata[94:83] !== want.line) begin
            $error("line_index expected %0d actual %0d", want.line, m_tdata[94:83]);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        cell_queue.insert(cell_queue.size(), diffuse_pixel(s_tdata, s_tuser));
      end
    end
    outstanding = cell_queue.size();
  end

  initial begin
    for (int k = 0; k < 4096; k++) next_row_err[k] = 0;
    fail_count = 0;
    outstanding = 0;
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Halftoner regression
// Drives directed and random pixel streams through the halftoner across
// several register settings, with random gaps and stalls, a long output
// hold-off and a full drain, while the checker predicts every result.
// ----------------------------------------------------------------------------

module tb;
  import edph_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // pixel
  logic        s_tuser;   // frame_start
  logic        m_tvalid;
  logic        m_tready;
  // dot_count[6:0], dot_mask[70:7], column[82:71], line_index[94:83], zero
  logic [95:0] m_tdata;
  logic        cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  int fail_count;
  int outstanding;
  int cycles;
  bit gaps_on;
  bit hold_go;
  bit hold_done;

  error_diffusion_pattern_halftoner_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  halftoner_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("error_diffusion_pattern_halftoner_core regression: fail");
      $finish;
    end
  end

  // The receiver stalls at random, and holds off for a long stretch once asked.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        m_tready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_done = 1;
      end
      m_tready <= !(gaps_on && $urandom_range(99) < 14);
    end
  end

  task automatic send_pixel(input logic [7:0] pix, input logic fs);
    while (gaps_on && $urandom_range(99) < 14) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= pix;
    s_tuser <= fs;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    wait (outstanding == 0);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
  endtask

  task automatic set_regs(input logic [3:0] n, input logic [12:0] w,
                          input logic [15:0] g, input logic h);
    drain();
    write_reg(REG_PATTERN_SIZE, 16'(n));
    write_reg(REG_IMAGE_WIDTH, 16'(w));
    write_reg(REG_COLOR_GAIN, g);
    write_reg(REG_HORIZONTAL_MODE, 16'(h));
    cfg_we <= 1'b0;
  endtask

  task automatic random_frame(input int count, input int hold_at, input int pause_at);
    logic [7:0] pix;
    for (int k = 0; k < count; k++) begin
      if (k == hold_at) hold_go = 1;
      if (k == pause_at) drain();
      case ($urandom_range(5))
        0: pix = 8'd0;
        1: pix = 8'd255;
        default: pix = 8'($urandom);
      endcase
      send_pixel(pix, (k == 0) || ($urandom_range(59) == 0));
    end
  endtask

  initial begin
    logic [12:0] w;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_PATTERN_SIZE;
    cfg_data = '0;
    cycles = 0;
    gaps_on = 0;
    hold_go = 0;
    hold_done = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_pixel(8'd0, 1'b1);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd128, 1'b0);
    send_pixel(8'd1, 1'b0);
    send_pixel(8'd100, 1'b1);
    set_regs(4'd8, 13'd3, 16'h8000, 1'b0);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd60, 1'b0);
    send_pixel(8'd200, 1'b0);
    send_pixel(8'd37, 1'b0);
    send_pixel(8'd99, 1'b0);
    send_pixel(8'd150, 1'b0);
    set_regs(4'd0, 13'd1, 16'h7fff, 1'b1);
    send_pixel(8'd50, 1'b1);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    set_regs(4'd15, 13'd0, 16'h0000, 1'b0);
    send_pixel(8'd77, 1'b1);
    send_pixel(8'd170, 1'b0);
    set_regs(4'd2, 13'd8191, 16'hf000, 1'b1);
    send_pixel(8'd85, 1'b1);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);

    gaps_on = 1;
    for (int p = 0; p < 10; p++) begin
      case (p)
        3: w = 13'd4096;
        7: w = 13'($urandom_range(20, 40));
        default: w = 13'($urandom_range(1, 12));
      endcase
      set_regs(4'($urandom), w, 16'($urandom), 1'($urandom));
      gaps_on = (p != 5);
      random_frame(48, (p == 2) ? 10 : -1, (p == 6) ? 20 : -1);
    end
    set_regs(4'd5, 13'd6, 16'd4096, 1'b1);
    random_frame(20, -1, -1);

    drain();
    if (fail_count == 0 && outstanding == 0) begin
      $display("error_diffusion_pattern_halftoner_core regression: pass");
    end else begin
      $display("error_diffusion_pattern_halftoner_core regression: fail");
    end
    $finish;
  end

endmodule
